>>> sv/rotated_blit_address_generator_macros.svh
// ----------------------------------------------------------------------------
// rotated_blit_address_generator_macros.svh
// Assertion macros shared by the rotated blit address generator.
// ----------------------------------------------------------------------------
`ifndef ROTATED_BLIT_ADDRESS_GENERATOR_MACROS_SVH
`define ROTATED_BLIT_ADDRESS_GENERATOR_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define RBAG_ASSERT_SAME(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("rbag assertion failed");

// Check that a condition implies another in the next cycle.
`define RBAG_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("rbag assertion failed");

`endif

>>> sv/rbag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbag_pkg
// Types and constants for the rotated blit address generator.
// ----------------------------------------------------------------------------
package rbag_pkg;

    // Default sizes
    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int ADDRESS_BITS_DEF  = 28;

    // Fixed field widths
    localparam int PIXEL_BITS     = 32;
    localparam int OUT_ADDR_BITS  = 28;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int STRIDE_BITS    = 16;
    localparam int DIM_REG_BITS   = 13;

    // Register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROTATION    = 3'd0,
        CFG_WIDE_PIXELS = 3'd1,
        CFG_DEST_STRIDE = 3'd2,
        CFG_DEST_WIDTH  = 3'd3,
        CFG_DEST_HEIGHT = 3'd4,
        CFG_RECT_WIDTH  = 3'd5,
        CFG_RECT_HEIGHT = 3'd6
    } cfg_index_t;

    // Rotation codes
    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_90   = 2'd1,
        ROT_180  = 2'd2,
        ROT_270  = 2'd3
    } rotation_t;

    // One result held in the output or skid register
    typedef struct packed {
        logic [OUT_ADDR_BITS-1:0] dest_address;
        logic [PIXEL_BITS-1:0]    pixel;
        logic                     last;
    } result_t;

endpackage
`default_nettype wire

>>> sv/rotated_blit_address_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_blit_address_generator
// Gives each source pixel of a raster-ordered rectangle the byte address
// where it lands in a destination bitmap rotated by 0, 90, 180 or 270 deg.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   pixel_in
// out       source     out_valid / out_stall dest_address, pixel_out, last_pixel
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per clock unless in_stall is high; each result is registered.
// A register write holds in_stall high through prod_pend and load_pend while
// the start offset is rebuilt through the registered stride multiplier.
// Reset leaves registers at rotation 0, 2-byte pixels, stride 0, sizes 1.
// An output register plus a skid register keep the input open for one
// more request while the output is stalled.
// ----------------------------------------------------------------------------
module rotated_blit_address_generator
    import rbag_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
    parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [PIXEL_BITS-1:0]     pixel_in,
    // output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [OUT_ADDR_BITS-1:0]       dest_address,
    output logic [PIXEL_BITS-1:0]          pixel_out,
    output logic                           last_pixel,
    // configuration channel
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

`include "rotated_blit_address_generator_macros.svh"

    localparam int DIM_BITS  = $clog2(MAX_DIMENSION);
    localparam int PROD_BITS = DIM_BITS + STRIDE_BITS;
    localparam int PROD_WIDE = (PROD_BITS > ADDRESS_BITS) ? PROD_BITS : ADDRESS_BITS;
    localparam int COL_BITS  = DIM_BITS + 2;
    localparam int COL_WIDE  = (COL_BITS > ADDRESS_BITS) ? COL_BITS : ADDRESS_BITS;
    localparam int OUT_WIDE  = (OUT_ADDR_BITS > ADDRESS_BITS) ? OUT_ADDR_BITS : ADDRESS_BITS;

    // Clamp a size register to 1..MAX_DIMENSION and return size minus one
    function automatic logic [DIM_BITS-1:0] dim_m1(input logic [DIM_REG_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        if (v == '0)
            r = '0;
        else if (32'(v) > 32'(MAX_DIMENSION))
            r = DIM_BITS'(MAX_DIMENSION - 1);
        else
            r = DIM_BITS'(v - DIM_REG_BITS'(1));
        return r;
    endfunction

    // Configuration registers
    rotation_t                 rotation_reg;
    logic                      wide_pixels_reg;
    logic [STRIDE_BITS-1:0]    dest_stride_reg;
    logic [DIM_REG_BITS-1:0]   dest_width_reg;
    logic [DIM_REG_BITS-1:0]   dest_height_reg;
    logic [DIM_REG_BITS-1:0]   rect_width_reg;
    logic [DIM_REG_BITS-1:0]   rect_height_reg;

    // Walk state
    logic [DIM_BITS-1:0]       column_count_reg, column_count_next;
    logic [DIM_BITS-1:0]       row_count_reg, row_count_next;
    logic [ADDRESS_BITS-1:0]   row_start_reg, row_start_next;
    logic [ADDRESS_BITS-1:0]   pixel_addr_reg, pixel_addr_next;
    logic [ADDRESS_BITS-1:0]   start_reg, start_next;
    logic [ADDRESS_BITS-1:0]   last_row_reg, last_row_next;
    logic                      prod_pend_reg, load_pend_reg;

    // Output and skid registers
    result_t                   out_reg, skid_reg, result_next;
    logic                      out_valid_reg, skid_valid_reg;

    logic                      cfg_write, cfg_known, busy, in_accept, out_take;
    logic [DIM_BITS-1:0]       rect_w_m1, rect_h_m1, dest_w_m1, dest_h_m1;
    logic [PROD_BITS-1:0]      prod_full;
    logic [PROD_WIDE-1:0]      prod_wide;
    logic [COL_BITS-1:0]       last_col_full;
    logic [COL_WIDE-1:0]       last_col_wide;
    logic [ADDRESS_BITS-1:0]   last_col, bpp, stride_ext, column_step, row_step;
    logic [OUT_WIDE-1:0]       out_addr_wide;
    logic                      end_of_row, last;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign busy      = prod_pend_reg || load_pend_reg;
    assign in_stall  = busy || skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    always_comb
    begin
        unique case (cfg_index_t'(cfg_index))
            CFG_ROTATION, CFG_WIDE_PIXELS, CFG_DEST_STRIDE, CFG_DEST_WIDTH,
            CFG_DEST_HEIGHT, CFG_RECT_WIDTH, CFG_RECT_HEIGHT: cfg_known = 1'b1;
            default:                                          cfg_known = 1'b0;
        endcase
    end

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg    <= ROT_NONE;
            wide_pixels_reg <= 1'b0;
            dest_stride_reg <= '0;
            dest_width_reg  <= DIM_REG_BITS'(1);
            dest_height_reg <= DIM_REG_BITS'(1);
            rect_width_reg  <= DIM_REG_BITS'(1);
            rect_height_reg <= DIM_REG_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROTATION:    rotation_reg    <= rotation_t'(cfg_data[1:0]);
                CFG_WIDE_PIXELS: wide_pixels_reg <= cfg_data[0];
                CFG_DEST_STRIDE: dest_stride_reg <= cfg_data;
                CFG_DEST_WIDTH:  dest_width_reg  <= cfg_data[DIM_REG_BITS-1:0];
                CFG_DEST_HEIGHT: dest_height_reg <= cfg_data[DIM_REG_BITS-1:0];
                CFG_RECT_WIDTH:  rect_width_reg  <= cfg_data[DIM_REG_BITS-1:0];
                CFG_RECT_HEIGHT: rect_height_reg <= cfg_data[DIM_REG_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Sizes minus one, bytes per pixel and steps
    assign rect_w_m1  = dim_m1(rect_width_reg);
    assign rect_h_m1  = dim_m1(rect_height_reg);
    assign dest_w_m1  = dim_m1(dest_width_reg);
    assign dest_h_m1  = dim_m1(dest_height_reg);
    assign bpp        = wide_pixels_reg ? ADDRESS_BITS'(4) : ADDRESS_BITS'(2);
    assign stride_ext = ADDRESS_BITS'(dest_stride_reg);

    always_comb
    begin
        unique case (rotation_reg)
            ROT_NONE:
            begin
                column_step = bpp;
                row_step    = stride_ext;
            end
            ROT_90:
            begin
                column_step = '0 - stride_ext;
                row_step    = bpp;
            end
            ROT_180:
            begin
                column_step = '0 - bpp;
                row_step    = '0 - stride_ext;
            end
            ROT_270:
            begin
                column_step = stride_ext;
                row_step    = '0 - bpp;
            end
            default:
            begin
                column_step = bpp;
                row_step    = stride_ext;
            end
        endcase
    end

    // Last destination row offset: one multiply, registered
    assign prod_full     = PROD_BITS'(dest_h_m1) * PROD_BITS'(dest_stride_reg);
    assign prod_wide     = PROD_WIDE'(prod_full);
    assign last_row_next = prod_wide[ADDRESS_BITS-1:0];

    always_ff @(posedge clk)
    begin
        last_row_reg <= last_row_next;
    end

    // Start offset from the registered product
    assign last_col_full = wide_pixels_reg ? (COL_BITS'(dest_w_m1) << 2)
                                           : (COL_BITS'(dest_w_m1) << 1);
    assign last_col_wide = COL_WIDE'(last_col_full);
    assign last_col      = last_col_wide[ADDRESS_BITS-1:0];

    always_comb
    begin
        unique case (rotation_reg)
            ROT_NONE: start_next = '0;
            ROT_90:   start_next = last_row_reg;
            ROT_180:  start_next = last_row_reg + last_col;
            ROT_270:  start_next = last_col;
            default:  start_next = '0;
        endcase
    end

    // Sequence the start offset rebuild after a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_pend_reg <= 1'b0;
            load_pend_reg <= 1'b0;
            start_reg     <= '0;
        end
        else
        begin
            prod_pend_reg <= cfg_write && cfg_known;
            load_pend_reg <= prod_pend_reg && !(cfg_write && cfg_known);
            if (load_pend_reg)
                start_reg <= start_next;
        end
    end

    // Position tracking and result for an accepted request
    assign end_of_row = column_count_reg >= rect_w_m1;
    assign last       = end_of_row && (row_count_reg >= rect_h_m1);

    assign out_addr_wide            = OUT_WIDE'(pixel_addr_reg);
    assign result_next.dest_address = out_addr_wide[OUT_ADDR_BITS-1:0];
    assign result_next.pixel        = wide_pixels_reg ? pixel_in
                                                      : {16'h0000, pixel_in[15:0]};
    assign result_next.last         = last;

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        row_start_next    = row_start_reg;
        pixel_addr_next   = pixel_addr_reg;
        priority if (cfg_write && cfg_known)
        begin
            column_count_next = '0;
            row_count_next    = '0;
        end
        else if (load_pend_reg)
        begin
            column_count_next = '0;
            row_count_next    = '0;
            row_start_next    = start_next;
            pixel_addr_next   = start_next;
        end
        else if (in_accept)
        begin
            if (last)
            begin
                column_count_next = '0;
                row_count_next    = '0;
                row_start_next    = start_reg;
                pixel_addr_next   = start_reg;
            end
            else if (end_of_row)
            begin
                column_count_next = '0;
                row_count_next    = row_count_reg + DIM_BITS'(1);
                row_start_next    = row_start_reg + row_step;
                pixel_addr_next   = row_start_reg + row_step;
            end
            else
            begin
                column_count_next = column_count_reg + DIM_BITS'(1);
                pixel_addr_next   = pixel_addr_reg + column_step;
            end
        end
        else
        begin
            // hold the walk position
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            row_start_reg    <= '0;
            pixel_addr_reg   <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            row_start_reg    <= row_start_next;
            pixel_addr_reg   <= pixel_addr_next;
        end
    end

    // Output register with skid: drain skid first, else fill output or skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= result_next;
            else
                skid_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_address = out_reg.dest_address;
    assign pixel_out    = out_reg.pixel;
    assign last_pixel   = out_reg.last;

    // Checks
    `RBAG_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `RBAG_ASSERT_NEXT(a_write_holds_input, clk, rst_n, cfg_write && cfg_known, in_stall)
    `RBAG_ASSERT_SAME(a_column_in_rect, clk, rst_n, 1'b1, column_count_reg <= rect_w_m1)

endmodule
`default_nettype wire
